[rtl/core/pff_pkg.sv]
// Shared types and constants for the packet fragment framer.
package pff_pkg;

  localparam int FRAME_BYTES  = 92;
  localparam int FULL_PAYLOAD = 90;
  localparam int MID_END      = 87;
  localparam int PAD_POS      = 88;
  localparam int MARK_POS     = 3;
  localparam int LEN_POS      = 2;

  localparam logic [7:0] MARK_FIRST = 8'haa;
  localparam logic [7:0] MARK_LATER = 8'h0f;
  localparam logic [7:0] MARK_FINAL = 8'hf0;
  localparam logic [7:0] PAD_BYTE   = 8'h00;

  typedef logic [7:0]  byte_t;
  typedef logic [31:0] word_t;
  typedef logic [6:0]  pos_t;
  typedef logic [$clog2(FULL_PAYLOAD)-1:0] addr_t;

  typedef struct packed {
    logic  valid;
    logic  final_frm;
    logic  run_end;
    pos_t  len;
    byte_t marker;
  } frame_req_t;

  typedef enum logic [1:0] {
    ES_IDLE,
    ES_READ,
    ES_LAND,
    ES_HOLD
  } eng_state_t;

endpackage

[rtl/core/pff_in_if.sv]
// Byte input channel: valid/ready handshake with data byte and last flag.
interface pff_in_if import pff_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

[rtl/core/pff_out_if.sv]
// Frame word output channel: valid/ready handshake with word and end flags.
interface pff_out_if import pff_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t frame_word;
  logic  frame_end;
  logic  packet_end;
  logic  run_last;

  modport source (output valid, output frame_word, output frame_end, output packet_end,
                  output run_last, input ready);
  modport sink (input valid, input frame_word, input frame_end, input packet_end,
                input run_last, output ready);
endinterface

[rtl/core/pff_ram.sv]
// Generic simple dual-port RAM with registered read data.
module pff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 90
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/pff_emit.sv]
// Frame emitter: reads the fragment store byte by byte and sends 23 frame words.
module pff_emit import pff_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  frame_req_t  req,
  output logic        busy,
  output addr_t       rd_addr,
  input  byte_t       rd_data,
  pff_out_if.source   out_chan
);

  eng_state_t state_r, state_nxt;
  pos_t       pos_r, pos_nxt;
  pos_t       len_r;
  logic       final_r;
  logic       run_end_r;
  byte_t      marker_r;

  logic       land_mem_r;
  byte_t      land_const_r;
  logic [1:0] land_lane_r;
  logic       land_v_r;
  logic [23:0] word_r;

  logic       out_valid_r, out_valid_nxt;
  word_t      out_word_r;
  logic       out_fend_r, out_pend_r, out_rlast_r;
  logic       load_out;

  logic [1:0] off;
  pos_t       idx;
  logic       src_mem;
  byte_t      const_byte;
  byte_t      land_byte;
  logic       tail;

  always_comb begin
    if (final_r) begin
      if (pos_r <= pos_t'(1))            off = 2'd0;
      else if (pos_r <= pos_t'(MID_END)) off = 2'd2;
      else                               off = 2'd3;
    end else begin
      if (pos_r <= pos_t'(2))            off = 2'd0;
      else if (pos_r <= pos_t'(MID_END)) off = 2'd1;
      else                               off = 2'd2;
    end
    idx = pos_r - {5'd0, off};
    src_mem = (pos_r != pos_t'(MARK_POS)) && !(final_r && pos_r == pos_t'(LEN_POS)) &&
              (pos_r != pos_t'(PAD_POS)) && (idx < len_r);
    if (pos_r == pos_t'(MARK_POS))                 const_byte = marker_r;
    else if (final_r && pos_r == pos_t'(LEN_POS))  const_byte = {1'b0, len_r};
    else                                           const_byte = PAD_BYTE;
  end

  assign rd_addr   = addr_t'(idx);
  assign land_byte = land_mem_r ? rd_data : land_const_r;
  assign tail      = (pos_r == pos_t'(FRAME_BYTES));
  assign busy      = (state_r != ES_IDLE);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    load_out      = 1'b0;
    case (state_r)
      ES_IDLE: begin
        if (req.valid) begin
          state_nxt = ES_READ;
          pos_nxt   = '0;
        end
      end
      ES_READ: begin
        pos_nxt = pos_r + pos_t'(1);
        if (pos_r[1:0] == 2'd3) begin
          state_nxt = ES_LAND;
        end
      end
      ES_LAND: begin
        load_out      = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ES_HOLD;
      end
      ES_HOLD: begin
        if (out_chan.ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = tail ? ES_IDLE : ES_READ;
        end
      end
      default: state_nxt = ES_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ES_IDLE;
      out_valid_r <= 1'b0;
      land_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      land_v_r    <= (state_r == ES_READ);
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    land_mem_r   <= src_mem;
    land_const_r <= const_byte;
    land_lane_r  <= pos_r[1:0];
    if (state_r == ES_IDLE && req.valid) begin
      len_r     <= req.len;
      final_r   <= req.final_frm;
      run_end_r <= req.run_end;
      marker_r  <= req.marker;
    end
    if (land_v_r) begin
      case (land_lane_r)
        2'd0:    word_r[7:0]   <= land_byte;
        2'd1:    word_r[15:8]  <= land_byte;
        2'd2:    word_r[23:16] <= land_byte;
        default: word_r        <= word_r;
      endcase
    end
    if (load_out) begin
      out_word_r  <= {land_byte, word_r};
      out_fend_r  <= tail;
      out_pend_r  <= tail && final_r;
      out_rlast_r <= tail && run_end_r;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.frame_word = out_word_r;
  assign out_chan.frame_end  = out_fend_r;
  assign out_chan.packet_end = out_pend_r;
  assign out_chan.run_last   = out_rlast_r;

endmodule

[rtl/core/packet_fragment_framer.sv]
// Packet fragment framer top level: byte intake, fragment store and frame emitter.
//
// Usage: packet bytes enter on in_chan, one per handshake, with last_byte set on
// the final byte of a packet. Frames of 23 little-endian 32-bit words leave on
// out_chan. A full frame (90 packet bytes) is sent after its 90th byte; a final
// frame (marker 0xF0, length byte) is sent after the byte with last_byte set, and
// follows a full frame in the same run when the packet length is a multiple of 90.
// Bytes are accepted one per cycle while no frame is being sent. A frame is read
// from the fragment RAM one byte per cycle while the emitter reads; each word
// takes 4 reads, a merge step and one output handshake, and the next reads
// wait for that handshake. in_chan.ready stays low until every word of the run
// is taken. When the receiver holds ready low, the current word is held on
// out_chan and the emitter waits. Reset clears the fill count, selects the first
// frame marker and empties the output; store contents are not cleared.
module packet_fragment_framer import pff_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  pff_in_if.sink     in_chan,
  pff_out_if.source  out_chan
);

  pos_t       fill_r, fill_nxt;
  logic       first_r, first_nxt;
  logic       pend_r, pend_nxt;
  frame_req_t req_r, req_nxt;
  logic       eng_busy;
  logic       accept;
  pos_t       cnt;
  addr_t      rd_addr;
  byte_t      rd_data;

  assign in_chan.ready = !eng_busy && !pend_r && !req_r.valid;
  assign accept        = in_chan.valid && in_chan.ready;
  assign cnt           = fill_r + pos_t'(1);

  always_comb begin
    fill_nxt  = fill_r;
    first_nxt = first_r;
    pend_nxt  = pend_r;
    req_nxt   = '0;
    if (accept) begin
      if (cnt == pos_t'(FULL_PAYLOAD)) begin
        req_nxt.valid     = 1'b1;
        req_nxt.final_frm = 1'b0;
        req_nxt.run_end   = !in_chan.last_byte;
        req_nxt.len       = pos_t'(FULL_PAYLOAD);
        req_nxt.marker    = first_r ? MARK_FIRST : MARK_LATER;
        fill_nxt          = '0;
        first_nxt         = 1'b0;
        pend_nxt          = in_chan.last_byte;
      end else if (in_chan.last_byte) begin
        req_nxt.valid     = 1'b1;
        req_nxt.final_frm = 1'b1;
        req_nxt.run_end   = 1'b1;
        req_nxt.len       = cnt;
        req_nxt.marker    = MARK_FINAL;
        fill_nxt          = '0;
        first_nxt         = 1'b1;
      end else begin
        fill_nxt = cnt;
      end
    end else if (pend_r && !eng_busy && !req_r.valid) begin
      req_nxt.valid     = 1'b1;
      req_nxt.final_frm = 1'b1;
      req_nxt.run_end   = 1'b1;
      req_nxt.len       = '0;
      req_nxt.marker    = MARK_FINAL;
      pend_nxt          = 1'b0;
      first_nxt         = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      first_r <= 1'b1;
      pend_r  <= 1'b0;
      req_r   <= '0;
    end else begin
      fill_r  <= fill_nxt;
      first_r <= first_nxt;
      pend_r  <= pend_nxt;
      req_r   <= req_nxt;
    end
  end

  pff_ram #(
    .WIDTH (8),
    .DEPTH (FULL_PAYLOAD)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (addr_t'(fill_r)),
    .wr_data (in_chan.data_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pff_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req_r),
    .busy     (eng_busy),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .out_chan (out_chan)
  );

endmodule
